@@ hdl/gaussian_density_voxel_splat_defines.svh @@
// Assertion helpers for the checker module.
`ifndef GAUSSIAN_DENSITY_VOXEL_SPLAT_DEFINES_SVH
`define GAUSSIAN_DENSITY_VOXEL_SPLAT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GDVS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdvs assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GDVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdvs assertion failed");

`endif

@@ hdl/gdvs_pkg.sv @@
package gdvs_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // axis distance in 1/512 angstrom units
   localparam int DELTA_W = 27;
   // 64 * radius^2 fits in this many bits
   localparam int LIM_W   = 38;

   localparam logic [23:0] DENS_MAX = 24'hFFFFFF;
   localparam logic [16:0] ONE_Q16  = 17'h10000;

   typedef enum logic [1:0] {
      OP_ACCUM = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_ORIGIN_Z   = 3'd2,
      CSR_VOXEL_SIZE = 3'd3,
      CSR_CELLS_X    = 3'd4,
      CSR_CELLS_Y    = 3'd5,
      CSR_CELLS_Z    = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CLEAR,
      ST_READ,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [23:0] atom_x;
      logic signed [23:0] atom_y;
      logic signed [23:0] atom_z;
      logic [15:0]        atom_radius;
      logic [14:0]        voxel_index;
   } req_type;

   typedef struct packed {
      logic [16:0] voxel_value;
      logic        index_error;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] origin_x;
      logic signed [23:0] origin_y;
      logic signed [23:0] origin_z;
      logic [15:0]        voxel_size;
      logic [5:0]         cells_x;
      logic [5:0]         cells_y;
      logic [5:0]         cells_z;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic clear_step;
      logic read_issue;
      logic respond;
   } dp_cmd_type;

   typedef struct packed {
      logic grid_empty;
      logic scan_last;
      logic clear_last;
      logic pipe_idle;
   } dp_status_type;

endpackage

@@ hdl/gdvs_csr.sv @@
module gdvs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [gdvs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gdvs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output gdvs_pkg::cfg_type                   cfg
);

   gdvs_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            gdvs_pkg::CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata;
            gdvs_pkg::CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata;
            gdvs_pkg::CSR_ORIGIN_Z:   cfg_in.origin_z   = csr_wdata;
            gdvs_pkg::CSR_VOXEL_SIZE: cfg_in.voxel_size = csr_wdata[15:0];
            gdvs_pkg::CSR_CELLS_X:    cfg_in.cells_x    = csr_wdata[5:0];
            gdvs_pkg::CSR_CELLS_Y:    cfg_in.cells_y    = csr_wdata[5:0];
            gdvs_pkg::CSR_CELLS_Z:    cfg_in.cells_z    = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.origin_z   <= '0;
         cfg_ff.voxel_size <= 16'd256;
         cfg_ff.cells_x    <= 6'd32;
         cfg_ff.cells_y    <= 6'd32;
         cfg_ff.cells_z    <= 6'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/gdvs_exp_rom.sv @@
module gdvs_exp_rom #(
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] idx,
   output logic [15:0]                        entry
);

   localparam int          U_RANGE      = 16;
   localparam int          SERIES_TERMS = 16;
   localparam logic [63:0] Q30_ONE      = 64'd1073741824;
   localparam logic [63:0] E_INV_Q30    = 64'd395007542;

   function automatic logic [63:0] div_small(input logic [63:0] t, input int k);
      case (k)
         2:       div_small = t / 2;
         3:       div_small = t / 3;
         4:       div_small = t / 4;
         5:       div_small = t / 5;
         6:       div_small = t / 6;
         7:       div_small = t / 7;
         8:       div_small = t / 8;
         9:       div_small = t / 9;
         10:      div_small = t / 10;
         11:      div_small = t / 11;
         12:      div_small = t / 12;
         13:      div_small = t / 13;
         14:      div_small = t / 14;
         15:      div_small = t / 15;
         16:      div_small = t / 16;
         default: div_small = t;
      endcase
   endfunction

   // exp(-idx*U_RANGE/depth) in Q1.15: series for the fraction, then e^-1 per integer
   function automatic logic [15:0] exp_entry(input int unsigned i);
      logic [63:0] x, n, f, sum, term, v;
      x    = ((64'(i) * 64'(U_RANGE)) << 30) / EXP_TABLE_DEPTH;
      n    = x >> 30;
      f    = x & (Q30_ONE - 64'd1);
      sum  = Q30_ONE;
      term = Q30_ONE;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         term = div_small((term * f) >> 30, k);
         if (k[0]) sum = (sum >= term) ? sum - term : 64'd0;
         else      sum = sum + term;
      end
      v = sum;
      for (int j = 0; j < U_RANGE; j++) begin
         if (64'(j) < n) v = (v * E_INV_Q30 + (Q30_ONE >> 1)) >> 30;
      end
      v = (v + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      return v[15:0];
   endfunction

   logic [15:0] tab [EXP_TABLE_DEPTH];
   logic [15:0] entry_ff;

   for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
      localparam logic [15:0] ENTRY = exp_entry(g);
      assign tab[g] = ENTRY;
   end

   always_ff @(posedge clock) begin
      entry_ff <= tab[idx];
   end

   assign entry = entry_ff;

endmodule

@@ hdl/gdvs_store.sv @@
module gdvs_store #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [23:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [23:0]   wr_data
);

   logic [23:0] mem [DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/gdvs_datapath.sv @@
module gdvs_datapath #(
   parameter int MAX_DIM         = 32,
   parameter int MAX_VOXELS      = 32768,
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gdvs_pkg::req_type       req,
   input  gdvs_pkg::cfg_type       cfg,
   input  gdvs_pkg::dp_cmd_type    cmd,
   output gdvs_pkg::dp_status_type status,
   output gdvs_pkg::rsp_type       rsp,
   output logic                    rsp_valid
);

   localparam int AW         = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
   localparam int QW         = $clog2(EXP_TABLE_DEPTH);
   localparam int DW         = gdvs_pkg::DELTA_W;
   localparam int LW         = gdvs_pkg::LIM_W;
   localparam int NW         = LW + QW;
   localparam int SW         = 2 * DW;
   localparam int CELL_CLAMP = (MAX_DIM > 63) ? 63 : MAX_DIM;

   function automatic logic signed [DW-1:0] axis_base(input logic signed [23:0] org,
                                                      input logic signed [23:0] atom,
                                                      input logic [15:0]        vs);
      logic signed [DW-1:0] o, a, v;
      o = DW'(org);
      a = DW'(atom);
      v = signed'(DW'(vs));
      return (o <<< 1) + v - (a <<< 1);
   endfunction

   logic [5:0] cx, cy, cz;
   logic [17:0] total;

   assign cx = (cfg.cells_x > 6'(CELL_CLAMP)) ? 6'(CELL_CLAMP) : cfg.cells_x;
   assign cy = (cfg.cells_y > 6'(CELL_CLAMP)) ? 6'(CELL_CLAMP) : cfg.cells_y;
   assign cz = (cfg.cells_z > 6'(CELL_CLAMP)) ? 6'(CELL_CLAMP) : cfg.cells_z;
   assign total = 18'(12'(cx) * 12'(cy)) * 18'(cz);

   // request context
   logic [1:0]           op_ff;
   logic [LW-1:0]        lim_ff;
   logic signed [DW-1:0] base_x_ff, base_y_ff, step_ff;
   logic                 idx_err_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic                 sat_ff;

   // scan counters
   logic [5:0]           x_ff, y_ff, z_ff;
   logic [AW-1:0]        lin_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;
   logic                 x_last, y_last, z_last;

   logic [AW-1:0]        clr_addr_ff;

   assign x_last = (x_ff == cx - 6'd1);
   assign y_last = (y_ff == cy - 6'd1);
   assign z_last = (z_ff == cz - 6'd1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req.opcode;
         lim_ff     <= LW'({32'(req.atom_radius) * 32'(req.atom_radius), 6'b0});
         base_x_ff  <= axis_base(cfg.origin_x, req.atom_x, cfg.voxel_size);
         base_y_ff  <= axis_base(cfg.origin_y, req.atom_y, cfg.voxel_size);
         step_ff    <= signed'(DW'({cfg.voxel_size, 1'b0}));
         idx_err_ff <= (18'(req.voxel_index) >= total) ||
                       (32'(req.voxel_index) >= 32'(MAX_VOXELS));
         rd_idx_ff  <= AW'(req.voxel_index);
         x_ff       <= '0;
         y_ff       <= '0;
         z_ff       <= '0;
         lin_ff     <= '0;
         dx_ff      <= axis_base(cfg.origin_x, req.atom_x, cfg.voxel_size);
         dy_ff      <= axis_base(cfg.origin_y, req.atom_y, cfg.voxel_size);
         dz_ff      <= axis_base(cfg.origin_z, req.atom_z, cfg.voxel_size);
      end else if (cmd.scan_step) begin
         lin_ff <= lin_ff + AW'(1);
         if (x_last) begin
            x_ff  <= '0;
            dx_ff <= base_x_ff;
            if (y_last) begin
               y_ff  <= '0;
               dy_ff <= base_y_ff;
               z_ff  <= z_ff + 6'd1;
               dz_ff <= dz_ff + step_ff;
            end else begin
               y_ff  <= y_ff + 6'd1;
               dy_ff <= dy_ff + step_ff;
            end
         end else begin
            x_ff  <= x_ff + 6'd1;
            dx_ff <= dx_ff + step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         if (clr_addr_ff == AW'(MAX_VOXELS - 1)) clr_addr_ff <= '0;
         else                                    clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // squares, one per stage
   logic                 s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [AW-1:0]        s1_lin_ff, s2_lin_ff, s3_lin_ff, s4_lin_ff, s5_lin_ff;
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff, s2_dy_ff, s2_dz_ff, s3_dz_ff;
   logic signed [SW-1:0] s2_sqx_ff, s3_sqx_ff, s3_sqy_ff, s4_sqx_ff, s4_sqy_ff, s4_sqz_ff;
   logic [LW+1:0]        s5_sum_ff;
   logic                 s5_big_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.scan_step;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_lin_ff <= lin_ff;
      s1_dx_ff  <= dx_ff;
      s1_dy_ff  <= dy_ff;
      s1_dz_ff  <= dz_ff;

      s2_lin_ff <= s1_lin_ff;
      s2_sqx_ff <= s1_dx_ff * s1_dx_ff;
      s2_dy_ff  <= s1_dy_ff;
      s2_dz_ff  <= s1_dz_ff;

      s3_lin_ff <= s2_lin_ff;
      s3_sqx_ff <= s2_sqx_ff;
      s3_sqy_ff <= s2_dy_ff * s2_dy_ff;
      s3_dz_ff  <= s2_dz_ff;

      s4_lin_ff <= s3_lin_ff;
      s4_sqx_ff <= s3_sqx_ff;
      s4_sqy_ff <= s3_sqy_ff;
      s4_sqz_ff <= s3_dz_ff * s3_dz_ff;

      // anything at or above 2^LW is outside the radius anyway
      s5_lin_ff <= s4_lin_ff;
      s5_big_ff <= (|s4_sqx_ff[SW-1:LW]) || (|s4_sqy_ff[SW-1:LW]) ||
                   (|s4_sqz_ff[SW-1:LW]);
      s5_sum_ff <= (LW+2)'(s4_sqx_ff[LW-1:0]) + (LW+2)'(s4_sqy_ff[LW-1:0]) +
                   (LW+2)'(s4_sqz_ff[LW-1:0]);
   end

   // restoring divider: idx = floor(d2 * depth / lim), one quotient bit a stage
   logic          div_v_ff   [QW+1];
   logic          div_hit_ff [QW+1];
   logic [AW-1:0] div_lin_ff [QW+1];
   logic [NW-1:0] div_rem_ff [QW+1];
   logic [QW-1:0] div_q_ff   [QW+1];
   logic [NW-1:0] div_sh     [QW];
   logic          div_ge     [QW];

   always_comb begin
      for (int j = 0; j < QW; j++) begin
         div_sh[j] = NW'(lim_ff) << (QW - 1 - j);
         div_ge[j] = (div_rem_ff[j] >= div_sh[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QW; j++) div_v_ff[j] <= 1'b0;
      end else begin
         div_v_ff[0] <= s5_v_ff;
         for (int j = 0; j < QW; j++) div_v_ff[j+1] <= div_v_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      div_lin_ff[0] <= s5_lin_ff;
      div_hit_ff[0] <= !s5_big_ff && (s5_sum_ff < (LW+2)'(lim_ff));
      div_rem_ff[0] <= NW'(s5_sum_ff[LW-1:0]) * NW'(EXP_TABLE_DEPTH);
      div_q_ff[0]   <= '0;
      for (int j = 0; j < QW; j++) begin
         div_lin_ff[j+1] <= div_lin_ff[j];
         div_hit_ff[j+1] <= div_hit_ff[j];
         div_rem_ff[j+1] <= div_ge[j] ? div_rem_ff[j] - div_sh[j] : div_rem_ff[j];
         div_q_ff[j+1]   <= div_q_ff[j] | (div_ge[j] ? QW'(1) << (QW - 1 - j) : QW'(0));
      end
   end

   // table and store read together, write back in the cycle after
   logic [15:0]   tab_entry;
   logic [23:0]   rd_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [23:0]   wr_data;
   logic          wb_v_ff, wb_hit_ff;
   logic [AW-1:0] wb_lin_ff;
   logic [16:0]   wb_add;
   logic [24:0]   wb_sum;
   logic          wb_sat;

   gdvs_exp_rom #(
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_exp_rom (
      .clock (clock),
      .idx   (div_q_ff[QW]),
      .entry (tab_entry)
   );

   assign rd_en   = div_v_ff[QW] || cmd.read_issue;
   assign rd_addr = cmd.read_issue ? rd_idx_ff : div_lin_ff[QW];

   gdvs_store #(
      .DEPTH(MAX_VOXELS),
      .AW   (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) wb_v_ff <= 1'b0;
      else       wb_v_ff <= div_v_ff[QW];
      wb_hit_ff <= div_hit_ff[QW];
      wb_lin_ff <= div_lin_ff[QW];
   end

   assign wb_add  = wb_hit_ff ? {tab_entry, 1'b0} : 17'd0;
   assign wb_sum  = {1'b0, rd_data} + 25'(wb_add);
   assign wb_sat  = (wb_sum >= 25'(gdvs_pkg::DENS_MAX));
   assign wr_en   = wb_v_ff || cmd.clear_step;
   assign wr_addr = cmd.clear_step ? clr_addr_ff : wb_lin_ff;
   assign wr_data = cmd.clear_step ? 24'd0 :
                    (wb_sat ? gdvs_pkg::DENS_MAX : wb_sum[23:0]);

   always_ff @(posedge clock) begin
      if (cmd.load)                 sat_ff <= 1'b0;
      else if (wb_v_ff && wb_sat)   sat_ff <= 1'b1;
   end

   // result register
   gdvs_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   always_comb begin
      rsp_in = '0;
      case (op_ff)
         gdvs_pkg::OP_READ: begin
            rsp_in.index_error = idx_err_ff;
            if (!idx_err_ff) begin
               rsp_in.voxel_value = (rd_data > 24'(gdvs_pkg::ONE_Q16)) ?
                                    gdvs_pkg::ONE_Q16 : rd_data[16:0];
            end
         end
         gdvs_pkg::OP_ACCUM: rsp_in.saturated = sat_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.respond;
      if (cmd.respond) rsp_ff <= rsp_in;
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   logic div_busy;

   always_comb begin
      div_busy = 1'b0;
      for (int j = 0; j <= QW; j++) div_busy = div_busy | div_v_ff[j];
   end

   assign status.grid_empty = (cx == 6'd0) || (cy == 6'd0) || (cz == 6'd0);
   assign status.scan_last  = (x_last && y_last && z_last) ||
                              (lin_ff == AW'(MAX_VOXELS - 1));
   assign status.clear_last = (clr_addr_ff == AW'(MAX_VOXELS - 1));
   assign status.pipe_idle  = !(s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff || s5_v_ff ||
                                div_busy || wb_v_ff);

endmodule

@@ hdl/gdvs_ctrl.sv @@
module gdvs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              opcode,
   input  gdvs_pkg::dp_status_type status,
   output gdvs_pkg::dp_cmd_type    cmd,
   output logic                    busy
);

   gdvs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= gdvs_pkg::ST_INIT;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != gdvs_pkg::ST_IDLE);
      case (state_ff)
         gdvs_pkg::ST_INIT: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = gdvs_pkg::ST_IDLE;
         end
         gdvs_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (opcode)
                  gdvs_pkg::OP_ACCUM:
                     state_in = status.grid_empty ? gdvs_pkg::ST_RESPOND : gdvs_pkg::ST_SCAN;
                  gdvs_pkg::OP_READ:  state_in = gdvs_pkg::ST_READ;
                  gdvs_pkg::OP_CLEAR: state_in = gdvs_pkg::ST_CLEAR;
                  default:            state_in = gdvs_pkg::ST_RESPOND;
               endcase
            end
         end
         gdvs_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = gdvs_pkg::ST_DRAIN;
         end
         gdvs_pkg::ST_DRAIN: begin
            // wait for the last write-back
            if (status.pipe_idle) state_in = gdvs_pkg::ST_RESPOND;
         end
         gdvs_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = gdvs_pkg::ST_RESPOND;
         end
         gdvs_pkg::ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = gdvs_pkg::ST_RESPOND;
         end
         gdvs_pkg::ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = gdvs_pkg::ST_IDLE;
         end
         default: state_in = gdvs_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ hdl/gaussian_density_voxel_splat.sv @@
// Gaussian density voxel splatter.
// Request channel: drive req_data and raise start; the request is taken at a
// clock edge where start is high and busy is low. Opcodes: accumulate an atom,
// read one voxel, clear the whole store.
// Result channel: every request gives one result on rsp_data, marked by
// rsp_valid for exactly one cycle; the receiver cannot stall it, so capture it then.
// Configuration: write csr_wdata to register csr_index with csr_we, only
// while busy is low.
// Steps, from accept to rsp_valid:
//   accumulate: every voxel of the grid in turn, one read-modify-write per
//               voxel in the store, then a drain of the pipeline
//   read: one store read; clear: every store entry zeroed; unused opcode: result only.
// busy drops in the cycle rsp_valid is shown, so a new request can be taken
// alongside the result.
// Reset: a clearing pass zeroes every store entry; busy stays
// high until it finishes.
module gaussian_density_voxel_splat #(
   parameter int MAX_DIM         = 32,
   parameter int MAX_VOXELS      = 32768,
   parameter int EXP_TABLE_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  gdvs_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output gdvs_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [gdvs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gdvs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   gdvs_pkg::cfg_type       cfg;
   gdvs_pkg::dp_cmd_type    cmd;
   gdvs_pkg::dp_status_type status;

   gdvs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gdvs_datapath #(
      .MAX_DIM        (MAX_DIM),
      .MAX_VOXELS     (MAX_VOXELS),
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp_data),
      .rsp_valid (rsp_valid)
   );

   gdvs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_data.opcode),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

endmodule

@@ hdl/gdvs_checker.sv @@
`include "gaussian_density_voxel_splat_defines.svh"

module gdvs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted request always makes the block busy
   `GDVS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // results only leave once the block is ready again
   `GDVS_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // one strobe per request
   `GDVS_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // a result closes a busy period
   `GDVS_ASSERT_IMP(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))

endmodule

bind gaussian_density_voxel_splat gdvs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

@@ tb/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_MAX   = 32;
   localparam int STORE_SIZE = 32768;
   localparam int TABLE_SIZE = 1024;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   gdvs_pkg::req_type                req = '0;
   logic                             rsp_valid;
   gdvs_pkg::rsp_type                rsp;
   logic                             csr_we = 1'b0;
   logic [gdvs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [gdvs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the block: configuration, Gaussian table, density store
   gdvs_pkg::cfg_type  cfg_shadow;
   int unsigned        gauss_q15 [TABLE_SIZE];
   int unsigned        density [STORE_SIZE];
   gdvs_pkg::rsp_type  pending_rsp [$];

   int                 fail_count = 0;
   int                 accum_count = 0;
   int                 read_count = 0;
   int                 clear_count = 0;
   int                 sat_count = 0;
   int                 cfg_count = 0;
   bit                 quiet_sender = 1'b0;

   gaussian_density_voxel_splat i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #50ms;
      $display("FAIL gaussian_density_voxel_splat");
      $finish;
   end

   function automatic void build_gauss_table();
      longint unsigned x, n, f, sum, term, v;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         x = ((longint'(i) * 16) << 30) / TABLE_SIZE;
         n = x >> 30;
         f = x & ((64'd1 << 30) - 1);
         sum = 64'd1 << 30;
         term = 64'd1 << 30;
         for (int k = 1; k <= 16; k++) begin
            term = ((term * f) >> 30) / k;
            if (k % 2 == 1) sum = (sum >= term) ? sum - term : 0;
            else sum = sum + term;
         end
         v = sum;
         while (n > 0) begin
            v = (v * 64'd395007542 + (64'd1 << 29)) >> 30;
            n--;
         end
         v = (v + 16384) >> 15;
         if (v > 32768) v = 32768;
         gauss_q15[i] = 32'(v);
      end
   endfunction

   function automatic int unsigned clamp_cells(logic [5:0] c);
      return (c > GRID_MAX) ? GRID_MAX : c;
   endfunction

   function automatic longint axis_offset(logic signed [23:0] org, int unsigned i,
                                          logic signed [23:0] atom);
      return 2 * longint'(org) + longint'(2 * i + 1) * longint'(cfg_shadow.voxel_size)
             - 2 * longint'(atom);
   endfunction

   // apply one request to the shadow store and return the expected result
   function automatic gdvs_pkg::rsp_type predict_splat(gdvs_pkg::req_type r);
      gdvs_pkg::rsp_type res;
      int unsigned       cx, cy, cz, lin;
      longint            dx, dy, dz;
      longint unsigned   d2, lim, idx, add, sum, total;
      res = '0;
      cx = clamp_cells(cfg_shadow.cells_x);
      cy = clamp_cells(cfg_shadow.cells_y);
      cz = clamp_cells(cfg_shadow.cells_z);
      if (r.opcode == gdvs_pkg::OP_ACCUM) begin
         lim = 64 * longint'(r.atom_radius) * longint'(r.atom_radius);
         for (int unsigned z = 0; z < cz; z++) begin
            dz = axis_offset(cfg_shadow.origin_z, z, r.atom_z);
            for (int unsigned y = 0; y < cy; y++) begin
               dy = axis_offset(cfg_shadow.origin_y, y, r.atom_y);
               for (int unsigned x = 0; x < cx; x++) begin
                  dx = axis_offset(cfg_shadow.origin_x, x, r.atom_x);
                  lin = x + y * cx + z * cx * cy;
                  if (lin >= STORE_SIZE) continue;
                  d2 = dx * dx + dy * dy + dz * dz;
                  add = 0;
                  if (r.atom_radius != 0 && d2 < lim) begin
                     idx = (d2 * TABLE_SIZE) / lim;
                     if (idx < TABLE_SIZE) add = longint'(gauss_q15[idx]) << 1;
                  end
                  sum = density[lin] + add;
                  if (sum >= gdvs_pkg::DENS_MAX) begin
                     sum = gdvs_pkg::DENS_MAX;
                     res.saturated = 1'b1;
                  end
                  density[lin] = 32'(sum);
               end
            end
         end
      end else if (r.opcode == gdvs_pkg::OP_READ) begin
         total = longint'(cx) * cy * cz;
         if (r.voxel_index >= total) res.index_error = 1'b1;
         else res.voxel_value = (density[r.voxel_index] > gdvs_pkg::ONE_Q16) ?
                                gdvs_pkg::ONE_Q16 : 17'(density[r.voxel_index]);
      end else if (r.opcode == gdvs_pkg::OP_CLEAR) begin
         foreach (density[i]) density[i] = 0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      gdvs_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.voxel_value !== want.voxel_value) begin
               $display("%0t: voxel_value expected %0d actual %0d", $time,
                        want.voxel_value, rsp.voxel_value);
               fail_count++;
            end
            if (rsp.index_error !== want.index_error) begin
               $display("%0t: index_error expected %0b actual %0b", $time,
                        want.index_error, rsp.index_error);
               fail_count++;
            end
            if (rsp.saturated !== want.saturated) begin
               $display("%0t: saturated expected %0b actual %0b", $time,
                        want.saturated, rsp.saturated);
               fail_count++;
            end
         end
      end
   end

   // hold start across back-to-back requests, lower it only before a gap
   task automatic send_request(gdvs_pkg::req_type r);
      int                gap;
      gdvs_pkg::rsp_type expect_rsp;
      gap = quiet_sender ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expect_rsp = predict_splat(r);
      pending_rsp = {pending_rsp, expect_rsp};
      case (r.opcode)
         gdvs_pkg::OP_ACCUM: accum_count++;
         gdvs_pkg::OP_READ:  read_count++;
         gdvs_pkg::OP_CLEAR: clear_count++;
         default: ;
      endcase
      if (r.opcode == gdvs_pkg::OP_ACCUM && expect_rsp.saturated) sat_count++;
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   // write all registers; the block must be idle
   task automatic load_config(gdvs_pkg::cfg_type c);
      drain();
      for (int i = gdvs_pkg::CSR_ORIGIN_X; i <= gdvs_pkg::CSR_CELLS_Z; i++) begin
         csr_we <= 1'b1;
         csr_index <= gdvs_pkg::CSR_INDEX_W'(i);
         case (i)
            gdvs_pkg::CSR_ORIGIN_X:   csr_wdata <= c.origin_x;
            gdvs_pkg::CSR_ORIGIN_Y:   csr_wdata <= c.origin_y;
            gdvs_pkg::CSR_ORIGIN_Z:   csr_wdata <= c.origin_z;
            gdvs_pkg::CSR_VOXEL_SIZE: csr_wdata <= gdvs_pkg::CSR_DATA_W'(c.voxel_size);
            gdvs_pkg::CSR_CELLS_X:    csr_wdata <= gdvs_pkg::CSR_DATA_W'(c.cells_x);
            gdvs_pkg::CSR_CELLS_Y:    csr_wdata <= gdvs_pkg::CSR_DATA_W'(c.cells_y);
            default:                  csr_wdata <= gdvs_pkg::CSR_DATA_W'(c.cells_z);
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_shadow = c;
      cfg_count++;
   endtask

   function automatic gdvs_pkg::req_type make_atom(longint ax, longint ay, longint az,
                                                   int r);
      gdvs_pkg::req_type q;
      q = '0;
      q.opcode = gdvs_pkg::OP_ACCUM;
      q.atom_x = 24'(ax);
      q.atom_y = 24'(ay);
      q.atom_z = 24'(az);
      q.atom_radius = 16'(r);
      q.voxel_index = 15'($urandom);
      return q;
   endfunction

   function automatic gdvs_pkg::req_type make_read(int idx);
      gdvs_pkg::req_type q;
      q = '0;
      q.opcode = gdvs_pkg::OP_READ;
      q.voxel_index = 15'(idx);
      q.atom_radius = 16'($urandom);
      return q;
   endfunction

   function automatic gdvs_pkg::req_type make_op(logic [1:0] op);
      gdvs_pkg::req_type q;
      q = '0;
      q.opcode = op;
      return q;
   endfunction

   function automatic gdvs_pkg::cfg_type make_config(longint ox, longint oy, longint oz,
                                                     int vs, int cx, int cy, int cz);
      gdvs_pkg::cfg_type c;
      c.origin_x = 24'(ox);
      c.origin_y = 24'(oy);
      c.origin_z = 24'(oz);
      c.voxel_size = 16'(vs);
      c.cells_x = 6'(cx);
      c.cells_y = 6'(cy);
      c.cells_z = 6'(cz);
      return c;
   endfunction

   task automatic test_reset_state();
      send_request(make_read(0));
      send_request(make_read(32767));
      send_request(make_op(gdvs_pkg::OP_NOP));
   endtask

   task automatic test_full_grid();
      send_request(make_atom(4096, 4096, 4096, 1024));
      send_request(make_read(16 + 16 * 32 + 16 * 1024));
      send_request(make_read(0));
      send_request(make_read(32767));
      send_request(make_op(gdvs_pkg::OP_CLEAR));
      send_request(make_read(16 + 16 * 32 + 16 * 1024));
   endtask

   task automatic test_config_extremes();
      // x count above the grid limit clamps; extreme origin and voxel size
      load_config(make_config(-8388608, 8388607, 0, 65535, 63, 1, 1));
      send_request(make_atom(-8388608, 8388607, 32767, 65535));
      send_request(make_atom(8388607, -8388608, -1, 65535));
      send_request(make_read(31));
      send_request(make_read(32));
      // zero voxel size, zero radius
      load_config(make_config(256, 256, 256, 0, 2, 2, 2));
      send_request(make_atom(256, 256, 256, 0));
      send_request(make_atom(256, 256, 256, 1));
      send_request(make_read(7));
      // empty grid
      load_config(make_config(0, 0, 0, 1, 0, 3, 3));
      send_request(make_atom(0, 0, 0, 512));
      send_request(make_read(0));
      send_request(make_op(gdvs_pkg::OP_NOP));
   endtask

   task automatic test_stacked_atoms();
      load_config(make_config(0, 0, 0, 256, 1, 1, 1));
      quiet_sender = 1'b1;
      // centered atom adds one full unit per request; the read clamps at one
      repeat (20) send_request(make_atom(128, 128, 128, 256));
      quiet_sender = 1'b0;
      send_request(make_read(0));
      send_request(make_op(gdvs_pkg::OP_CLEAR));
      send_request(make_read(0));
   endtask

   task automatic test_random_traffic();
      gdvs_pkg::req_type q;
      gdvs_pkg::cfg_type c;
      int                pick, product, vs;
      longint            lo, span;
      for (int n = 0; n < 60; n++) begin
         if (n % 20 == 0) begin
            vs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(16, 512);
            c = make_config($signed($urandom_range(0, 4095)) - 2048,
                            $signed($urandom_range(0, 4095)) - 2048,
                            $signed($urandom_range(0, 4095)) - 2048, vs,
                            $urandom_range(1, 4), $urandom_range(1, 4),
                            $urandom_range(1, 4));
            if (n == 40) c.cells_x = 6'd32;
            load_config(c);
            quiet_sender = (n == 20);
         end
         if (n == 50) drain();
         product = clamp_cells(cfg_shadow.cells_x) * clamp_cells(cfg_shadow.cells_y)
                   * clamp_cells(cfg_shadow.cells_z);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 7) == 0) begin
               q = make_atom($urandom, $urandom, $urandom, $urandom);
            end else begin
               span = 2 * longint'(cfg_shadow.voxel_size) * 4 + 1;
               lo = longint'(cfg_shadow.origin_x) - cfg_shadow.voxel_size;
               q = make_atom(lo + $urandom_range(0, int'(span - 1)),
                             longint'(cfg_shadow.origin_y) - cfg_shadow.voxel_size
                             + $urandom_range(0, int'(span - 1)),
                             longint'(cfg_shadow.origin_z) - cfg_shadow.voxel_size
                             + $urandom_range(0, int'(span - 1)),
                             $urandom_range(1, 4 * cfg_shadow.voxel_size + 1));
            end
         end else if (pick < 92) begin
            q = make_read(($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, product + 1));
         end else if (pick < 94) begin
            q = make_op(gdvs_pkg::OP_CLEAR);
         end else begin
            q = make_op(gdvs_pkg::OP_NOP);
            q.atom_x = 24'($urandom);
            q.voxel_index = 15'($urandom);
         end
         send_request(q);
      end
   endtask

   initial begin
      build_gauss_table();
      foreach (density[i]) density[i] = 0;
      cfg_shadow = make_config(0, 0, 0, 256, 32, 32, 32);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_full_grid();
      test_config_extremes();
      test_stacked_atoms();
      test_random_traffic();
      drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d accumulates (%0d saturating), %0d reads, %0d clears,",
               accum_count, sat_count, read_count, clear_count);
      $display("across %0d register settings including clamped and empty grids.",
               cfg_count);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS gaussian_density_voxel_splat");
      end else begin
         $display("FAIL gaussian_density_voxel_splat");
      end
      $finish;
   end
endmodule
